// File: hw/rtl/bclpd_pkg.sv
// shared types, event codes and register defaults for the button event detector
`timescale 1ns / 1ps

package bclpd_pkg;

    localparam int unsigned TimeWidth = 32;
    localparam int unsigned CfgWidth  = 16;

    localparam logic [CfgWidth-1:0] DEF_DEBOUNCE = 16'd20;
    localparam logic [CfgWidth-1:0] DEF_CLICK    = 16'd300;
    localparam logic [CfgWidth-1:0] DEF_LONG     = 16'd800;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_CLICK    = 2'd1,
        REG_LONG     = 2'd2,
        REG_UNUSED   = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DOWN   = 3'd1,
        EV_UP     = 3'd2,
        EV_CLICK  = 3'd3,
        EV_DOUBLE = 3'd4,
        EV_LONG   = 3'd5
    } event_t;

    typedef struct packed {
        logic [CfgWidth-1:0] debounce_time;
        logic [CfgWidth-1:0] click_window;
        logic [CfgWidth-1:0] long_press_time;
    } cfg_t;

    typedef struct packed {
        logic                 debounced_level;
        logic                 last_raw_level;
        logic                 long_done;
        logic                 click_waiting;
        logic [TimeWidth-1:0] raw_change_time;
        logic [TimeWidth-1:0] press_begin_time;
        logic [TimeWidth-1:0] release_time;
    } btn_state_t;

endpackage

// File: hw/rtl/bclpd_step.sv
// next-state and event logic for one button sample
`timescale 1ns / 1ps

module bclpd_step
    import bclpd_pkg::*;
(
    input  cfg_t                 cfg,
    input  btn_state_t           cur,
    input  logic                 raw_pressed,
    input  logic [TimeWidth-1:0] time_now,
    output btn_state_t           nxt,
    output event_t               ev
);

    logic [CfgWidth-1:0]  deb;
    logic [CfgWidth-1:0]  win;
    logic [CfgWidth-1:0]  lng;
    logic [TimeWidth-1:0] change_time;
    logic [TimeWidth-1:0] stable_diff;
    logic [TimeWidth-1:0] press_diff;
    logic [TimeWidth-1:0] release_diff;
    logic                 edge_ok;
    logic                 in_window;
    logic                 window_over;

    assign deb = (cfg.debounce_time == '0) ? DEF_DEBOUNCE : cfg.debounce_time;
    assign win = (cfg.click_window == '0) ? DEF_CLICK : cfg.click_window;
    assign lng = (cfg.long_press_time == '0) ? DEF_LONG : cfg.long_press_time;

    assign change_time  = (raw_pressed != cur.last_raw_level) ? time_now
                                                               : cur.raw_change_time;
    assign stable_diff  = time_now - change_time;
    assign press_diff   = time_now - cur.press_begin_time;
    assign release_diff = time_now - cur.release_time;

    assign edge_ok     = (raw_pressed != cur.debounced_level)
                       && (stable_diff >= {{(TimeWidth-CfgWidth){1'b0}}, deb});
    assign in_window   = release_diff <= {{(TimeWidth-CfgWidth){1'b0}}, win};
    assign window_over = !in_window;

    always_comb
    begin
        nxt                 = cur;
        nxt.last_raw_level  = raw_pressed;
        nxt.raw_change_time = change_time;
        ev                  = EV_NONE;
        priority if (edge_ok)
        begin
            nxt.debounced_level = raw_pressed;
            if (raw_pressed)
            begin
                nxt.press_begin_time = time_now;
                nxt.long_done        = 1'b0;
                ev                   = EV_DOWN;
            end
            else
            begin
                ev = EV_UP;
                priority if (cur.long_done)
                begin
                    nxt.click_waiting = 1'b0;
                end
                else if (cur.click_waiting && in_window)
                begin
                    nxt.click_waiting = 1'b0;
                    ev                = EV_DOUBLE;
                end
                else
                begin
                    nxt.click_waiting = 1'b1;
                    nxt.release_time  = time_now;
                end
            end
        end
        else if (cur.debounced_level && !cur.long_done
                 && (press_diff >= {{(TimeWidth-CfgWidth){1'b0}}, lng}))
        begin
            nxt.long_done     = 1'b1;
            nxt.click_waiting = 1'b0;
            ev                = EV_LONG;
        end
        else if (cur.click_waiting && window_over)
        begin
            nxt.click_waiting = 1'b0;
            ev                = EV_CLICK;
        end
        else
        begin
            ev = EV_NONE;
        end
    end

endmodule

// File: hw/rtl/button_click_long_press_detector.sv
// top level of the button debounce, click, double click and long press detector
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------
//  input    | in_valid / in_ready    | raw_pressed, time_now
//  output   | out_valid / out_ready  | event_code
//  config   | cfg_write_en           | cfg_index, cfg_data
//
//  one item per cycle sustained while out_ready is held high; an item passes through the input
//  register, then the step logic, then the result register
//  reset gives released at time 0 and the default register values
//  a stalled result holds in its register while the input register still fills
`timescale 1ns / 1ps

module button_click_long_press_detector
    import bclpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 raw_pressed,
    input  logic [TimeWidth-1:0] time_now,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           event_code,
    input  logic                 cfg_write_en,
    input  logic [1:0]           cfg_index,
    input  logic [CfgWidth-1:0]  cfg_data
);

    cfg_t                 cfg_reg;
    btn_state_t           state_reg;
    btn_state_t           state_next;
    logic                 s1_valid_reg;
    logic                 s1_raw_reg;
    logic [TimeWidth-1:0] s1_time_reg;
    logic                 out_valid_reg;
    event_t               event_reg;
    event_t               event_next;
    logic                 s1_advance;
    reg_index_t           cfg_sel;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;
    assign cfg_sel    = reg_index_t'(cfg_index);

    bclpd_step u_step (
        .cfg         (cfg_reg),
        .cur         (state_reg),
        .raw_pressed (s1_raw_reg),
        .time_now    (s1_time_reg),
        .nxt         (state_next),
        .ev          (event_next)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_time   <= DEF_DEBOUNCE;
            cfg_reg.click_window    <= DEF_CLICK;
            cfg_reg.long_press_time <= DEF_LONG;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_sel)
                REG_DEBOUNCE: cfg_reg.debounce_time   <= cfg_data;
                REG_CLICK:    cfg_reg.click_window    <= cfg_data;
                REG_LONG:     cfg_reg.long_press_time <= cfg_data;
                default:      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_raw_reg  <= raw_pressed;
            s1_time_reg <= time_now;
        end
    end

    // detector state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
            event_reg     <= EV_NONE;
        end
        else
        begin
            if (s1_advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
                event_reg     <= event_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
